// File: rtl/core/bdvb_pkg.sv
// ----------------------------------------------------------------------------
// bdvb_pkg
// Shared types and fixed field widths of the bounded delay value buffer.
// ----------------------------------------------------------------------------
package bdvb_pkg;

   // fixed field widths of the item ports
   localparam int SLACK_W    = 8;
   localparam int VAL_IN_W   = 16;
   localparam int DROP_OUT_W = 5;
   localparam int COUNT_W    = 32;
   localparam int SUM_W      = 48;

   // item function codes
   localparam logic FUNC_ARRIVAL = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   // control of the shared compare unit
   typedef struct packed {
      logic clear;      // forget the current best entry
      logic check;      // offer the candidate entry
      logic find_max;   // 1: maximum, low index wins; 0: minimum, high index wins
      logic final_cmp;  // compare best value against the item value
   } scan_ctl_type;

endpackage

// File: rtl/core/bdvb_slot_mem.sv
// ----------------------------------------------------------------------------
// bdvb_slot_mem
// Slot memory holding slack and value of each packet slot, one write port
// and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdvb_slot_mem
   import bdvb_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int VW    = 16
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [SLACK_W-1:0] rd_slack,
   output logic [VW-1:0]      rd_value,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [SLACK_W-1:0] wr_slack,
   input  logic [VW-1:0]      wr_value
);

   logic [SLACK_W-1:0] slack_mem [DEPTH];
   logic [VW-1:0]      value_mem [DEPTH];
   logic [SLACK_W-1:0] rd_slack_ff;
   logic [VW-1:0]      rd_value_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slack_mem[wr_addr] <= wr_slack;
         value_mem[wr_addr] <= wr_value;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_slack_ff <= slack_mem[rd_addr];
         rd_value_ff <= value_mem[rd_addr];
      end
   end

   assign rd_slack = rd_slack_ff;
   assign rd_value = rd_value_ff;

endmodule

// File: rtl/core/bdvb_cmp_unit.sv
// ----------------------------------------------------------------------------
// bdvb_cmp_unit
// Shared value comparator with the best-entry register of the slot scan,
// reused at the end of an arrival to test the minimum against the new value.
// ----------------------------------------------------------------------------
module bdvb_cmp_unit
   import bdvb_pkg::*;
#(
   parameter int AW = 4,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  scan_ctl_type  ctl,
   input  logic [AW-1:0] cand_idx,
   input  logic [VW-1:0] cand_value,
   input  logic [VW-1:0] item_value,
   output logic          best_found,
   output logic [AW-1:0] best_idx,
   output logic [VW-1:0] best_value,
   output logic          best_le_item
);

   logic          found_ff;
   logic [AW-1:0] idx_ff;
   logic [VW-1:0] value_ff;
   logic [VW-1:0] op_a;
   logic [VW-1:0] op_b;
   logic          a_lt_b;
   logic          a_eq_b;
   logic          take;

   // operand selection into the single comparator
   assign op_a   = ctl.final_cmp ? value_ff : cand_value;
   assign op_b   = ctl.final_cmp ? item_value : value_ff;
   assign a_lt_b = (op_a < op_b);
   assign a_eq_b = (op_a == op_b);

   // candidate replaces the best entry
   always_comb begin
      if (!found_ff) begin
         take = 1'b1;
      end else if (ctl.find_max) begin
         take = !(a_lt_b || a_eq_b);
      end else begin
         take = a_lt_b || a_eq_b;
      end
   end

   // best entry tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (ctl.check && take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.check && take && !ctl.clear) begin
         idx_ff   <= cand_idx;
         value_ff <= cand_value;
      end
   end

   assign best_found   = found_ff;
   assign best_idx     = idx_ff;
   assign best_value   = value_ff;
   assign best_le_item = a_lt_b || a_eq_b;

endmodule

// File: rtl/core/bounded_delay_value_buffer.sv
// ----------------------------------------------------------------------------
// bounded_delay_value_buffer
// Packet slot buffer with greedy value admission, slack expiry and
// highest-value transmit, plus running drop, admit and send statistics.
// ----------------------------------------------------------------------------
// Usage:
//  The req channel carries one item: func selects a packet arrival (with
//  packet_slack and packet_value) or a time tick. Each item gives exactly one
//  result on the rsp channel with per-item flags and the running totals.
//  Both channels use valid/stall; an item moves on an edge with valid high
//  and stall low.
//  Each item is worked by a scan over all slots, one slot per cycle through
//  the slot memory read port and a shared comparator, then a drain and an
//  update cycle. The result is registered when the update cycle commits;
//  only then does the sequencer return to idle and take the next item, so
//  req_stall is high while an item is in work.
//  The result sits in an output register; while rsp_stall holds it, the next
//  item is still accepted and scanned, and waits in its update cycle.
//  Reset empties all slots (valid bits only, no clearing pass), clears
//  the totals and drops any result not yet taken.
// ----------------------------------------------------------------------------
module bounded_delay_value_buffer
   import bdvb_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [SLACK_W-1:0]    req_packet_slack,
   input  logic [VAL_IN_W-1:0]   req_packet_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_admitted,
   output logic [DROP_OUT_W-1:0] rsp_dropped_now,
   output logic                  rsp_sent,
   output logic [VAL_IN_W-1:0]   rsp_sent_value,
   output logic [COUNT_W-1:0]    rsp_total_dropped,
   output logic [COUNT_W-1:0]    rsp_total_admitted,
   output logic [COUNT_W-1:0]    rsp_total_sent,
   output logic [SUM_W-1:0]      rsp_total_sent_value
);

   localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DCW = $clog2(SLOTS + 1);
   localparam int VW  = VALUE_BITS;

   // sequencer and scan control
   state_type          state_ff;
   state_type          state_in;
   logic [AW-1:0]      idx_ff;
   logic               chk_vld_ff;
   logic [AW-1:0]      chk_idx_ff;
   logic [SLOTS-1:0]   full_ff;

   // item registers
   logic               func_ff;
   logic [SLACK_W-1:0] slack_ff;
   logic [VW-1:0]      value_ff;
   logic [DCW-1:0]     drop_now_ff;
   logic               free_found_ff;
   logic [AW-1:0]      free_idx_ff;

   // statistics and result
   logic [COUNT_W-1:0]    drop_count_ff;
   logic [COUNT_W-1:0]    admit_count_ff;
   logic [COUNT_W-1:0]    send_count_ff;
   logic [SUM_W-1:0]      value_sum_ff;
   logic                  rsp_valid_ff;
   logic                  admitted_ff;
   logic [DROP_OUT_W-1:0] dropped_now_ff;
   logic                  sent_ff;
   logic [VAL_IN_W-1:0]   sent_value_ff;

   // memory and compare unit connections
   logic               mem_rd_en;
   logic [SLACK_W-1:0] rd_slack;
   logic [VW-1:0]      rd_value;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [SLACK_W-1:0] wr_slack;
   logic [VW-1:0]      wr_value;
   scan_ctl_type       scan_ctl;
   logic               best_found;
   logic [AW-1:0]      best_idx;
   logic [VW-1:0]      best_value;
   logic               best_le_item;

   // derived control
   logic               accept;
   logic               commit;
   logic               chk_full;
   logic               slack_live;
   logic               expire;
   logic               arr_admit;
   logic [AW-1:0]      arr_target;
   logic               tick_send;

   bdvb_slot_mem #(
      .DEPTH (SLOTS),
      .AW    (AW),
      .VW    (VW)
   ) u_slot_mem (
      .clock    (clock),
      .rd_en    (mem_rd_en),
      .rd_addr  (idx_ff),
      .rd_slack (rd_slack),
      .rd_value (rd_value),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_slack (wr_slack),
      .wr_value (wr_value)
   );

   bdvb_cmp_unit #(
      .AW (AW),
      .VW (VW)
   ) u_cmp_unit (
      .clock        (clock),
      .reset        (reset),
      .ctl          (scan_ctl),
      .cand_idx     (chk_idx_ff),
      .cand_value   (rd_value),
      .item_value   (value_ff),
      .best_found   (best_found),
      .best_idx     (best_idx),
      .best_value   (best_value),
      .best_le_item (best_le_item)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == AW'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      accept     = (state_ff == ST_IDLE) && req_valid;
      commit     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
      mem_rd_en  = (state_ff == ST_SCAN);
      chk_full   = chk_vld_ff && full_ff[chk_idx_ff];
      slack_live = (rd_slack > SLACK_W'(1));
      expire     = chk_full && (func_ff == FUNC_TICK) && !slack_live;
      arr_admit  = free_found_ff || best_le_item;
      arr_target = free_found_ff ? free_idx_ff : best_idx;
      tick_send  = (func_ff == FUNC_TICK) && best_found;

      scan_ctl.clear     = accept;
      scan_ctl.check     = chk_full && ((func_ff == FUNC_ARRIVAL) || slack_live);
      scan_ctl.find_max  = (func_ff == FUNC_TICK);
      scan_ctl.final_cmp = (state_ff == ST_UPDATE);

      // memory write: slack decrement on tick scan, packet store on arrival
      wr_en    = 1'b0;
      wr_addr  = chk_idx_ff;
      wr_slack = rd_slack - SLACK_W'(1);
      wr_value = rd_value;
      if (chk_full && (func_ff == FUNC_TICK) && slack_live) begin
         wr_en = 1'b1;
      end else if (commit && (func_ff == FUNC_ARRIVAL) && arr_admit) begin
         wr_en    = 1'b1;
         wr_addr  = arr_target;
         wr_slack = slack_ff;
         wr_value = value_ff;
      end
   end

   // control state, slot valid bits and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         chk_vld_ff     <= 1'b0;
         full_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         drop_count_ff  <= '0;
         admit_count_ff <= '0;
         send_count_ff  <= '0;
         value_sum_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= (state_ff == ST_SCAN);
         if (expire) begin
            full_ff[chk_idx_ff] <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            if (func_ff == FUNC_ARRIVAL) begin
               if (arr_admit) begin
                  full_ff[arr_target] <= 1'b1;
                  admit_count_ff      <= admit_count_ff + COUNT_W'(1);
               end
               if (!free_found_ff) begin
                  drop_count_ff <= drop_count_ff + COUNT_W'(1);
               end
            end else begin
               drop_count_ff <= drop_count_ff + COUNT_W'(drop_now_ff);
               if (best_found) begin
                  full_ff[best_idx] <= 1'b0;
                  send_count_ff     <= send_count_ff + COUNT_W'(1);
                  value_sum_ff      <= value_sum_ff + SUM_W'(best_value);
               end
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and scan payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff       <= req_func;
         slack_ff      <= req_packet_slack;
         value_ff      <= VW'(req_packet_value);
         drop_now_ff   <= '0;
         free_found_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         if (state_ff == ST_SCAN) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (expire) begin
            drop_now_ff <= drop_now_ff + DCW'(1);
         end
         if (chk_vld_ff && !full_ff[chk_idx_ff] && (func_ff == FUNC_ARRIVAL)
             && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= chk_idx_ff;
         end
      end
      chk_idx_ff <= idx_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (commit) begin
         admitted_ff   <= (func_ff == FUNC_ARRIVAL) && arr_admit;
         sent_ff       <= tick_send;
         sent_value_ff <= tick_send ? VAL_IN_W'(best_value) : '0;
         if (func_ff == FUNC_ARRIVAL) begin
            dropped_now_ff <= free_found_ff ? DROP_OUT_W'(0) : DROP_OUT_W'(1);
         end else begin
            dropped_now_ff <= DROP_OUT_W'(drop_now_ff);
         end
      end
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_admitted         = admitted_ff;
   assign rsp_dropped_now      = dropped_now_ff;
   assign rsp_sent             = sent_ff;
   assign rsp_sent_value       = sent_value_ff;
   assign rsp_total_dropped    = drop_count_ff;
   assign rsp_total_admitted   = admit_count_ff;
   assign rsp_total_sent       = send_count_ff;
   assign rsp_total_sent_value = value_sum_ff;

   // a result never both admits and sends
   a_admit_xor_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(admitted_ff && sent_ff))
      else $error("result both admitted and sent");

   // no transmit means a zero sent value
   a_idle_sent_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !sent_ff) |-> (sent_value_ff == '0))
      else $error("sent value without a transmit");

   // the transmitted slot is freed
   a_sent_slot_freed: assert property (@(posedge clock) disable iff (reset)
      (commit && tick_send) |=> !full_ff[$past(best_idx)])
      else $error("transmitted slot still full");

   // admit count moves by at most one per cycle
   a_admit_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((admit_count_ff == $past(admit_count_ff))
         || (admit_count_ff == $past(admit_count_ff) + COUNT_W'(1))))
      else $error("admit count jumped");

   // scan data only arrives while the scan runs
   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("slot check outside the scan");

endmodule
